FILE: rtl/core/compare_timer_peripheral_core_macros.svh
// Assertion macros shared by the timer checker.
`ifndef COMPARE_TIMER_PERIPHERAL_CORE_MACROS_SVH
`define COMPARE_TIMER_PERIPHERAL_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CTP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("timer check failed");

// Antecedent in one cycle, consequent in the next.
`define CTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

FILE: rtl/core/ctp_pkg.sv
// Types, codes and defaults for the compare timer.
package ctp_pkg;

  localparam int unsigned NumChannelsDef = 4;
  localparam int unsigned CountWidthDef  = 16;
  localparam int unsigned FieldW         = 16;
  localparam int unsigned FlagW          = 5;
  localparam int unsigned ApbAddrW       = 3;
  localparam int unsigned ApbDataW       = 32;

  localparam logic [FieldW-1:0] ReloadReset = 16'hFFFF;

  // Request actions
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  // Register map of the request stream
  localparam logic [3:0] REG_CTRL   = 4'd0;
  localparam logic [3:0] REG_STATUS = 4'd1;
  localparam logic [3:0] REG_IRQ_EN = 4'd2;
  localparam logic [3:0] REG_COUNT  = 4'd3;
  localparam logic [3:0] REG_EVENT  = 4'd4;
  localparam logic [3:0] REG_CMP0   = 4'd5;

  // Configuration register select (paddr word bit)
  localparam logic CFG_PRESCALE = 1'b0;
  localparam logic CFG_RELOAD   = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        reg_index;
    logic [FieldW-1:0] write_data;
  } ctp_in_t;

  typedef struct packed {
    logic [FieldW-1:0] read_data;
    logic              irq;
    logic [FlagW-1:0]  pending_events;
  } ctp_out_t;

  typedef struct packed {
    logic [FieldW-1:0] prescale_divisor;
    logic [FieldW-1:0] reload_value;
  } ctp_cfg_t;

  // Request handed to the timer core
  typedef struct packed {
    logic    fire;
    ctp_in_t item;
  } ctp_ctrl_t;

endpackage

FILE: rtl/core/ctp_timer.sv
// Timer state and single-pass request processing.
module ctp_timer
  import ctp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctp_ctrl_t ctrl_i,
  input  ctp_cfg_t  cfg_i,
  output ctp_out_t  res_o
);

  logic [FieldW-1:0]      presc_q, presc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   run_q, run_d;
  logic [FlagW-1:0]       flags_q, flags_d;
  logic [FlagW-1:0]       irq_en_q, irq_en_d;
  logic [COUNT_WIDTH-1:0] cmp_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] reload_m;
  logic                   step;
  logic [FieldW-1:0]      rd;
  logic [FlagW-1:0]       pend;
  ctp_in_t                item;

  assign item     = ctrl_i.item;
  assign reload_m = COUNT_WIDTH'(cfg_i.reload_value);

  // Next state and read data for the request in hand
  always_comb begin
    presc_d  = presc_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    flags_d  = flags_q;
    irq_en_d = irq_en_q;
    cmp_d    = cmp_q;
    rd       = '0;
    step     = 1'b0;

    unique case (item.action)
      ACT_TICK: begin
        if (run_q) begin
          if (presc_q >= cfg_i.prescale_divisor) begin
            presc_d = '0;
            step    = 1'b1;
          end else begin
            presc_d = presc_q + FieldW'(1);
          end
        end
      end
      ACT_READ: begin
        unique case (item.reg_index)
          REG_CTRL:   rd = FieldW'(run_q);
          REG_STATUS: rd = FieldW'(flags_q);
          REG_IRQ_EN: rd = FieldW'(irq_en_q);
          REG_COUNT:  rd = FieldW'(cnt_q);
          REG_EVENT:  rd = '0;
          default: begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
              if (item.reg_index == REG_CMP0 + 4'(ch)) rd = FieldW'(cmp_q[ch]);
            end
          end
        endcase
      end
      ACT_WRITE: begin
        unique case (item.reg_index)
          REG_CTRL:   run_d    = item.write_data[0];
          REG_STATUS: flags_d  = flags_q & item.write_data[FlagW-1:0];
          REG_IRQ_EN: irq_en_d = item.write_data[FlagW-1:0];
          REG_COUNT:  cnt_d    = COUNT_WIDTH'(item.write_data);
          REG_EVENT: begin
            // update event generation
            if (item.write_data[0]) begin
              presc_d    = '0;
              cnt_d      = '0;
              flags_d[0] = 1'b1;
            end
          end
          default: begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
              if (item.reg_index == REG_CMP0 + 4'(ch)) begin
                cmp_d[ch] = COUNT_WIDTH'(item.write_data);
              end
            end
          end
        endcase
      end
      default: ;
    endcase

    // counter step: wrap at reload, then compare against the new count
    if (step) begin
      if (cnt_q >= reload_m) begin
        cnt_d      = '0;
        flags_d[0] = 1'b1;
      end else begin
        cnt_d = cnt_q + COUNT_WIDTH'(1);
      end
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (cmp_q[ch] == cnt_d) flags_d[ch+1] = 1'b1;
      end
    end
  end

  assign pend = flags_d & irq_en_d;

  assign res_o.read_data      = rd;
  assign res_o.irq            = |pend;
  assign res_o.pending_events = pend;

  // State registers, updated only when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q  <= '0;
      cnt_q    <= '0;
      run_q    <= 1'b0;
      flags_q  <= '0;
      irq_en_q <= '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) cmp_q[ch] <= '0;
    end else if (ctrl_i.fire) begin
      presc_q  <= presc_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      flags_q  <= flags_d;
      irq_en_q <= irq_en_d;
      cmp_q    <= cmp_d;
    end
  end

endmodule

FILE: rtl/core/compare_timer_peripheral_core.sv
// Top level of the compare timer: APB config, request pipeline, timer core.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+-----------
//  in_req   | in        | in_req_valid_i / in_req_stall_o   | ctp_in_t
//  out_req  | out       | out_req_valid_o / out_req_stall_i | ctp_out_t
//  apb      | in        | psel, penable, pwrite, pready     | paddr, pwdata
//
// One request per cycle sustained while out_req does not stall. A request passes the
// input register, then the timer update and compares (combinational), then the
// result register. The timer state is updated as the result register loads.
// A stall on out_req holds the result and backs up into in_req_stall_o.
// Reset clears timer state; prescale divisor 0, reload 65535.
module compare_timer_peripheral_core
  import ctp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_req_valid_i,
  output logic                in_req_stall_o,
  input  ctp_in_t             in_req_i,
  output logic                out_req_valid_o,
  input  logic                out_req_stall_i,
  output ctp_out_t            out_req_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  ctp_cfg_t  cfg_q;
  logic      in_valid_q;
  ctp_in_t   in_item_q;
  logic      out_valid_q;
  ctp_out_t  out_res_q;
  ctp_out_t  res;
  ctp_ctrl_t ctrl;
  logic      fire;
  logic      cfg_we;

  // APB configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_divisor <= '0;
      cfg_q.reload_value     <= ReloadReset;
    end else if (cfg_we) begin
      unique case (paddr[2])
        CFG_PRESCALE: cfg_q.prescale_divisor <= pwdata[FieldW-1:0];
        CFG_RELOAD:   cfg_q.reload_value     <= pwdata[FieldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_PRESCALE: prdata = ApbDataW'(cfg_q.prescale_divisor);
      CFG_RELOAD:   prdata = ApbDataW'(cfg_q.reload_value);
      default:      prdata = '0;
    endcase
  end

  // Pipeline control: process when the result register is free or draining
  assign fire           = in_valid_q & (~out_valid_q | ~out_req_stall_i);
  assign in_req_stall_o = in_valid_q & ~fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_req_stall_o) begin
      in_valid_q <= in_req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req_valid_i && !in_req_stall_o) in_item_q <= in_req_i;
  end

  assign ctrl.fire = fire;
  assign ctrl.item = in_item_q;

  ctp_timer #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_timer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_req_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_res_q <= res;
  end

  assign out_req_valid_o = out_valid_q;
  assign out_req_o       = out_res_q;

endmodule

FILE: rtl/core/ctp_checker.sv
// Port-level checks for the compare timer, bound to the top level.
`include "compare_timer_peripheral_core_macros.svh"

module ctp_checker
  import ctp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_req_valid_i,
  input logic     in_req_stall_o,
  input logic     out_req_valid_o,
  input logic     out_req_stall_i,
  input ctp_out_t out_req_o
);

  // irq is exactly the OR of the pending events
  `CTP_ASSERT(a_irq_pending, out_req_valid_o |-> (out_req_o.irq == (out_req_o.pending_events != '0)))

  // input backs up only behind a held result
  `CTP_ASSERT(a_stall_cause, in_req_stall_o |-> (out_req_valid_o && out_req_stall_i))

  // every accepted request is followed, after the input and result registers, by a valid result
  `CTP_ASSERT(a_latency, (in_req_valid_i && !in_req_stall_o) |-> ##2 out_req_valid_o)

  // a stalled result holds
  `CTP_ASSERT_NEXT(a_out_hold, out_req_valid_o && out_req_stall_i, out_req_valid_o && $stable(out_req_o))

endmodule

bind compare_timer_peripheral_core ctp_checker u_ctp_checker (.*);

FILE: dv/compare_timer_peripheral_core_tb.sv
// Self-checking testbench for the compare timer core: directed, random and backpressure tests.
module compare_timer_peripheral_core_tb;
  import ctp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned REPORT_MAX     = 10;

  // Codes outside the defined map
  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [3:0] REG_UNUSED_LO = 4'd9;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;
  localparam logic [3:0] REG_CMP_LAST  = REG_CMP0 + 4'(NumChannelsDef - 1);

  // DUT connections; the inputs driven here are known from time zero
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_req_valid = 1'b0;
  logic                in_req_stall;
  ctp_in_t             in_req       = '0;
  logic                out_req_valid;
  logic                out_req_stall = 1'b0;
  ctp_out_t            out_req;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Timer shadow state
  logic [FieldW-1:0] cfg_prescale  = '0;
  logic [FieldW-1:0] cfg_reload    = ReloadReset;
  logic [FieldW-1:0] prescale_cnt  = '0;
  logic [FieldW-1:0] count_value   = '0;
  logic              run_bit       = 1'b0;
  logic [FlagW-1:0]  status_bits   = '0;
  logic [FlagW-1:0]  irq_enables   = '0;
  logic [FieldW-1:0] compare_regs [NumChannelsDef];

  ctp_out_t    expected_responses [$];
  int unsigned fail_count  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off    = 1'b0;

  compare_timer_peripheral_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_req_valid_i  (in_req_valid),
    .in_req_stall_o  (in_req_stall),
    .in_req_i        (in_req),
    .out_req_valid_o (out_req_valid),
    .out_req_stall_i (out_req_stall),
    .out_req_o       (out_req),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    foreach (compare_regs[i]) compare_regs[i] = '0;
  end

  // Applies one request to the shadow timer and returns the response it yields
  function automatic ctp_out_t timer_response(input ctp_in_t req);
    ctp_out_t          resp;
    logic [FieldW-1:0] rd;
    logic [FlagW-1:0]  pend;
    int unsigned       ch;
    rd = '0;
    case (req.action)
      ACT_TICK: begin
        if (run_bit) begin
          if (prescale_cnt >= cfg_prescale) begin
            prescale_cnt = '0;
            // counter step: wrap past reload, then compare on the new value
            if (count_value >= cfg_reload) begin
              count_value    = '0;
              status_bits[0] = 1'b1;
            end else begin
              count_value = count_value + 1'b1;
            end
            for (ch = 0; ch < NumChannelsDef; ch++) begin
              if (compare_regs[ch] == count_value) status_bits[ch+1] = 1'b1;
            end
          end else begin
            prescale_cnt = prescale_cnt + 1'b1;
          end
        end
      end
      ACT_READ: begin
        case (req.reg_index)
          REG_CTRL:   rd = FieldW'(run_bit);
          REG_STATUS: rd = FieldW'(status_bits);
          REG_IRQ_EN: rd = FieldW'(irq_enables);
          REG_COUNT:  rd = count_value;
          REG_EVENT:  rd = '0;
          default: begin
            if (req.reg_index >= REG_CMP0 && req.reg_index <= REG_CMP_LAST)
              rd = compare_regs[req.reg_index - REG_CMP0];
          end
        endcase
      end
      ACT_WRITE: begin
        case (req.reg_index)
          REG_CTRL:   run_bit = req.write_data[0];
          REG_STATUS: status_bits = status_bits & req.write_data[FlagW-1:0];
          REG_IRQ_EN: irq_enables = req.write_data[FlagW-1:0];
          REG_COUNT:  count_value = req.write_data;
          REG_EVENT: begin
            if (req.write_data[0]) begin
              prescale_cnt   = '0;
              count_value    = '0;
              status_bits[0] = 1'b1;
            end
          end
          default: begin
            if (req.reg_index >= REG_CMP0 && req.reg_index <= REG_CMP_LAST)
              compare_regs[req.reg_index - REG_CMP0] = req.write_data;
          end
        endcase
      end
      default: ;
    endcase
    pend                = status_bits & irq_enables;
    resp.read_data      = rd;
    resp.irq            = |pend;
    resp.pending_events = pend;
    return resp;
  endfunction

  function automatic ctp_in_t make_request(input logic [1:0] act, input logic [3:0] idx,
                                           input logic [FieldW-1:0] data);
    ctp_in_t req;
    req.action     = act;
    req.reg_index  = idx;
    req.write_data = data;
    return req;
  endfunction

  // Mostly ticks, with register traffic biased toward values that hit the reload range
  function automatic ctp_in_t random_request();
    ctp_in_t     req;
    int unsigned pick;
    req.action     = ACT_TICK;
    req.reg_index  = 4'($urandom_range(0, 15));
    req.write_data = FieldW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.action = ACT_TICK;
    end else if (pick < 70) begin
      req.action = ACT_READ;
      if ($urandom_range(0, 4) != 0) req.reg_index = 4'($urandom_range(0, REG_CMP_LAST));
    end else if (pick < 97) begin
      req.action    = ACT_WRITE;
      req.reg_index = 4'($urandom_range(0, REG_CMP_LAST));
      case (req.reg_index)
        REG_CTRL:  req.write_data[0] = ($urandom_range(0, 6) != 0);
        REG_STATUS, REG_IRQ_EN, REG_EVENT: ;
        default: begin
          // counter or compare: usually inside the reload range
          if ($urandom_range(0, 3) != 0) req.write_data = FieldW'($urandom_range(0, cfg_reload));
        end
      endcase
    end else begin
      req.action    = ($urandom_range(0, 1) != 0) ? ACT_UNUSED : ACT_WRITE;
      req.reg_index = 4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
    end
    return req;
  endfunction

  // Sends one request in bursts with random gaps; valid stays high between requests of a burst
  task automatic send_request(input ctp_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_req_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_req_valid <= 1'b1;
    in_req       <= req;
    do @(posedge clk_i); while (in_req_stall);
    expected_responses.push_back(timer_response(req));
  endtask

  // Drops valid and lets every outstanding response drain
  task automatic wait_idle();
    in_req_valid <= 1'b0;
    burst_left = 0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready, then an idle cycle
  task automatic write_config(input logic sel, input logic [FieldW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (sel == CFG_PRESCALE) cfg_prescale = value;
    else cfg_reload = value;
  endtask

  // Register map, field extremes, wrap above reload, event and unused codes
  task automatic test_directed();
    wait_idle();
    write_config(CFG_PRESCALE, 16'd1);
    write_config(CFG_RELOAD, 16'd3);
    send_request(make_request(ACT_READ, REG_COUNT, 16'hFFFF));
    send_request(make_request(ACT_WRITE, REG_IRQ_EN, 16'hFFFF));
    send_request(make_request(ACT_WRITE, REG_CMP0, 16'd2));
    send_request(make_request(ACT_WRITE, REG_CMP_LAST, 16'hFFFF));
    send_request(make_request(ACT_WRITE, REG_CMP0 + 4'd1, 16'h0000));
    send_request(make_request(ACT_WRITE, REG_CTRL, 16'hFFFF));
    repeat (4) send_request(make_request(ACT_TICK, REG_CTRL, 16'h0000));
    send_request(make_request(ACT_READ, REG_STATUS, 16'h0000));
    send_request(make_request(ACT_WRITE, REG_STATUS, 16'hFFFD));
    send_request(make_request(ACT_WRITE, REG_COUNT, 16'hFFFF));
    repeat (2) send_request(make_request(ACT_TICK, REG_UNUSED_HI, 16'hFFFF));
    send_request(make_request(ACT_WRITE, REG_STATUS, 16'h0000));
    send_request(make_request(ACT_WRITE, REG_EVENT, 16'hFFFE));
    send_request(make_request(ACT_WRITE, REG_EVENT, 16'h0001));
    send_request(make_request(ACT_READ, REG_EVENT, 16'h0000));
    send_request(make_request(ACT_READ, REG_UNUSED_HI, 16'h0000));
    send_request(make_request(ACT_WRITE, REG_UNUSED_LO, 16'hFFFF));
    send_request(make_request(ACT_UNUSED, REG_UNUSED_HI, 16'hFFFF));
    send_request(make_request(ACT_READ, REG_CMP_LAST, 16'h0000));
    send_request(make_request(ACT_WRITE, REG_CTRL, 16'h0000));
    send_request(make_request(ACT_TICK, REG_CTRL, 16'h0000));
    send_request(make_request(ACT_READ, REG_CTRL, 16'h0000));
  endtask

  // Random traffic under one prescale/reload setting, starting with the timer running
  task automatic test_random(input logic [FieldW-1:0] prescale, input logic [FieldW-1:0] reload,
                             input int unsigned num_requests);
    wait_idle();
    write_config(CFG_PRESCALE, prescale);
    write_config(CFG_RELOAD, reload);
    send_request(make_request(ACT_WRITE, REG_CTRL, 16'h0001));
    repeat (num_requests) send_request(random_request());
  endtask

  // Long receiver hold while requests keep coming, so the input backs up
  task automatic test_backpressure();
    wait_idle();
    write_config(CFG_PRESCALE, 16'd0);
    write_config(CFG_RELOAD, 16'd15);
    send_request(make_request(ACT_WRITE, REG_CTRL, 16'h0001));
    hold_off = 1'b1;
    repeat (80) send_request(random_request());
  endtask

  // Receiver: random stall runs, or one long hold when asked
  always begin : receiver
    int unsigned stall_run;
    logic        stall_level;
    @(posedge clk_i);
    if (hold_off) begin
      out_req_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_off  = 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_level = ($urandom_range(0, 3) == 0);
        stall_run   = $urandom_range(1, 20);
      end
      stall_run--;
      out_req_stall <= stall_level;
    end
  end

  // Response checker against the oldest expectation
  always @(posedge clk_i) begin
    ctp_out_t want;
    if (rst_ni && out_req_valid && !out_req_stall) begin
      if (expected_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected response: read_data=%h irq=%b pending=%b",
                   out_req.read_data, out_req.irq, out_req.pending_events);
      end else begin
        want = expected_responses.pop_front();
        if (out_req.read_data !== want.read_data || out_req.irq !== want.irq ||
            out_req.pending_events !== want.pending_events) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("response mismatch: read_data exp %h got %h, irq exp %b got %b, %s",
                     want.read_data, out_req.read_data, want.irq, out_req.irq,
                     $sformatf("pending exp %b got %b", want.pending_events,
                               out_req.pending_events));
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a request
  always @(posedge clk_i) begin
    if ((in_req_valid && !in_req_stall) || (out_req_valid && !out_req_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("compare_timer_peripheral_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(16'd0, 16'd7, 140);
    test_random(16'd2, 16'd30, 140);
    test_random(16'd0, 16'd0, 80);
    test_random(16'hFFFF, 16'hFFFF, 60);
    test_random(16'd0, 16'hFFFF, 120);
    test_random(16'd3, 16'd5, 120);
    test_backpressure();
    wait_idle();
    if (expected_responses.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("compare_timer_peripheral_core_tb: done, clean");
    end else begin
      $display("compare_timer_peripheral_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: compare_timer_peripheral_core.f
+incdir+rtl/core
rtl/core/ctp_pkg.sv
rtl/core/ctp_timer.sv
rtl/core/compare_timer_peripheral_core.sv
rtl/core/ctp_checker.sv
dv/compare_timer_peripheral_core_tb.sv
